FILE: hw/rtl/vfce_pkg.sv
// Shared types, constants and lookup tables for the voxel face-cull emitter.
// Used by the sequencer, the datapath, the top level and the port checker.
`default_nettype none

package vfce_pkg;

    // Chunk geometry and field widths.
    localparam int EDGE  = 16;
    localparam int VW    = 4;
    localparam int DEPTH = EDGE * EDGE * EDGE;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = 8;
    localparam int CFGW  = 16;
    localparam int WW    = 20;
    localparam int PCW   = 4;

    // Item operations.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MESH  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_CHUNK_X = 2'd0;
    localparam logic [1:0] REG_CHUNK_Y = 2'd1;
    localparam logic [1:0] REG_CHUNK_Z = 2'd2;

    // Face codes; the neighbor select also uses them, plus a center code.
    localparam logic [2:0] FACE_NX   = 3'd0;
    localparam logic [2:0] FACE_PX   = 3'd1;
    localparam logic [2:0] FACE_NY   = 3'd2;
    localparam logic [2:0] FACE_PY   = 3'd3;
    localparam logic [2:0] FACE_NZ   = 3'd4;
    localparam logic [2:0] FACE_PZ   = 3'd5;
    localparam logic [2:0] NS_CENTER = 3'd6;

    localparam logic [2:0] VERT_LAST = 3'd5;

    // Jump conditions of the control word.
    localparam logic [2:0] JC_NEXT   = 3'd0;
    localparam logic [2:0] JC_JUMP   = 3'd1;
    localparam logic [2:0] JC_ACCEPT = 3'd2;
    localparam logic [2:0] JC_ZERO   = 3'd3;
    localparam logic [2:0] JC_EMPTY  = 3'd4;
    localparam logic [2:0] JC_EMIT   = 3'd5;

    typedef struct packed {
        logic           ready;
        logic [2:0]     nsel;
        logic           cap_en;
        logic [2:0]     cap_bit;
        logic           seek;
        logic           emit;
        logic [2:0]     jc;
        logic [PCW-1:0] target;
    } t_ctl;

    typedef struct packed {
        logic go;
        logic data_zero;
        logic mask_empty;
        logic fire;
        logic vert_last;
    } t_stat;

    localparam logic [2:0] CORNER_TAB [36] = '{
        3'd0, 3'd6, 3'd2, 3'd0, 3'd4, 3'd6,
        3'd1, 3'd3, 3'd7, 3'd1, 3'd7, 3'd5,
        3'd0, 3'd5, 3'd4, 3'd0, 3'd1, 3'd5,
        3'd2, 3'd6, 3'd7, 3'd2, 3'd7, 3'd3,
        3'd0, 3'd2, 3'd3, 3'd0, 3'd3, 3'd1,
        3'd4, 3'd7, 3'd6, 3'd4, 3'd5, 3'd7
    };

    localparam logic [2:0] TEX_TAB [36] = '{
        3'd3, 3'd4, 3'd2, 3'd3, 3'd5, 3'd4,
        3'd5, 3'd4, 3'd2, 3'd5, 3'd2, 3'd3,
        3'd6, 3'd5, 3'd7, 3'd6, 3'd4, 3'd5,
        3'd3, 3'd2, 3'd0, 3'd3, 3'd0, 3'd1,
        3'd5, 3'd4, 3'd2, 3'd5, 3'd2, 3'd3,
        3'd3, 3'd4, 3'd2, 3'd3, 3'd5, 3'd4
    };

    function automatic logic [5:0] tab_idx(input logic [2:0] face, input logic [2:0] vert);
        return 6'(6'(face) * 6'd6 + 6'(vert));
    endfunction

    function automatic logic [2:0] corner_lut(input logic [2:0] face, input logic [2:0] vert);
        logic [5:0] idx;
        idx = tab_idx(face, vert);
        return (idx < 6'd36) ? CORNER_TAB[idx] : 3'd0;
    endfunction

    function automatic logic [2:0] tex_lut(input logic [2:0] face, input logic [2:0] vert);
        logic [5:0] idx;
        idx = tab_idx(face, vert);
        return (idx < 6'd36) ? TEX_TAB[idx] : 3'd0;
    endfunction

    // Linear store address, x major, z minor.
    function automatic logic [AW-1:0] addr_of(input logic [VW-1:0] x, input logic [VW-1:0] y,
                                              input logic [VW-1:0] z);
        return AW'(int'(x) * EDGE * EDGE + int'(y) * EDGE + int'(z));
    endfunction

    // World position, wrapped to the output width.
    function automatic logic [WW-1:0] world_pos(input logic [CFGW-1:0] chunk,
                                                input logic [VW-1:0] v);
        return WW'(WW'($signed(chunk)) * WW'(EDGE) + WW'(v));
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/voxel_face_cull_emitter.sv
// Write request: accepted in the idle step and stored at that edge; ready again next cycle.
// Mesh request: 8 steps read the center and six neighbors and fill the visibility mask, then
// one seek step plus an emit step of six vertices per visible face and a final seek; an air
// center goes back to idle after its read, and the emit step holds while the output stalls.
// Synchronous active-low reset clears the sequencer, mask, output valid and chunk registers;
// the voxel store is never cleared.
`default_nettype none

module voxel_face_cull_emitter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_op,
    input  logic [vfce_pkg::VW-1:0]          i_vx,
    input  logic [vfce_pkg::VW-1:0]          i_vy,
    input  logic [vfce_pkg::VW-1:0]          i_vz,
    input  logic [vfce_pkg::BW-1:0]          i_block_id,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [vfce_pkg::WW-1:0]   o_world_x,
    output logic signed [vfce_pkg::WW-1:0]   o_world_y,
    output logic signed [vfce_pkg::WW-1:0]   o_world_z,
    output logic [2:0]                       o_corner,
    output logic [2:0]                       o_tex_slot,
    output logic [2:0]                       o_face,
    output logic                             o_last,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [vfce_pkg::CFGW-1:0]        i_cfg_data
);

    vfce_pkg::t_ctl           ctl;
    vfce_pkg::t_stat          stat;
    logic                     ram_we;
    logic [vfce_pkg::AW-1:0]  ram_waddr, ram_raddr;
    logic [vfce_pkg::BW-1:0]  ram_wdata, ram_rdata;
    logic [vfce_pkg::WW-1:0]  wx, wy, wz;

    vfce_ram #(
        .WIDTH(vfce_pkg::BW),
        .DEPTH(vfce_pkg::DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    vfce_useq u_useq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (stat),
        .o_ctl  (ctl)
    );

    vfce_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_stat     (stat),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_op       (i_op),
        .i_vx       (i_vx),
        .i_vy       (i_vy),
        .i_vz       (i_vz),
        .i_block_id (i_block_id),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_ram_we   (ram_we),
        .o_ram_waddr(ram_waddr),
        .o_ram_wdata(ram_wdata),
        .o_ram_raddr(ram_raddr),
        .i_ram_rdata(ram_rdata),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_world_x  (wx),
        .o_world_y  (wy),
        .o_world_z  (wz),
        .o_corner   (o_corner),
        .o_tex_slot (o_tex_slot),
        .o_face     (o_face),
        .o_last     (o_last)
    );

    assign o_world_x = $signed(wx);
    assign o_world_y = $signed(wy);
    assign o_world_z = $signed(wz);

endmodule

`default_nettype wire

FILE: hw/rtl/vfce_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module vfce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/vfce_useq.sv
// Step counter and control store of the emitter's sequencer.
// Depends on vfce_pkg for the control word, status and jump codes.
`default_nettype none

module vfce_useq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vfce_pkg::t_stat i_stat,
    output vfce_pkg::t_ctl  o_ctl
);

    localparam logic [vfce_pkg::PCW-1:0] S_IDLE = 4'd0;
    localparam logic [vfce_pkg::PCW-1:0] S_RDC  = 4'd1;
    localparam logic [vfce_pkg::PCW-1:0] S_RNX  = 4'd2;
    localparam logic [vfce_pkg::PCW-1:0] S_RPX  = 4'd3;
    localparam logic [vfce_pkg::PCW-1:0] S_RNY  = 4'd4;
    localparam logic [vfce_pkg::PCW-1:0] S_RPY  = 4'd5;
    localparam logic [vfce_pkg::PCW-1:0] S_RNZ  = 4'd6;
    localparam logic [vfce_pkg::PCW-1:0] S_RPZ  = 4'd7;
    localparam logic [vfce_pkg::PCW-1:0] S_CPZ  = 4'd8;
    localparam logic [vfce_pkg::PCW-1:0] S_SEEK = 4'd9;
    localparam logic [vfce_pkg::PCW-1:0] S_EMIT = 4'd10;

    logic [vfce_pkg::PCW-1:0] r_pc;
    logic [vfce_pkg::PCW-1:0] n_pc;
    logic [vfce_pkg::PCW-1:0] pc_inc;
    vfce_pkg::t_ctl           ctl;

    // Control store. Each neighbor's data is captured into the visibility mask by the step
    // that issues the next neighbor read, or by S_CPZ for the last neighbor.
    function automatic vfce_pkg::t_ctl rom(input logic [vfce_pkg::PCW-1:0] pc);
        vfce_pkg::t_ctl w;
        w      = '0;
        w.nsel = vfce_pkg::NS_CENTER;
        w.jc   = vfce_pkg::JC_NEXT;
        unique case (pc)
            S_IDLE: begin
                w.ready = 1'b1;
                w.jc    = vfce_pkg::JC_ACCEPT;
            end
            S_RDC: begin
                w.nsel = vfce_pkg::NS_CENTER;
            end
            S_RNX: begin
                w.nsel   = vfce_pkg::FACE_NX;
                w.jc     = vfce_pkg::JC_ZERO;
                w.target = S_IDLE;
            end
            S_RPX: begin
                w.nsel    = vfce_pkg::FACE_PX;
                w.cap_en  = 1'b1;
                w.cap_bit = vfce_pkg::FACE_NX;
            end
            S_RNY: begin
                w.nsel    = vfce_pkg::FACE_NY;
                w.cap_en  = 1'b1;
                w.cap_bit = vfce_pkg::FACE_PX;
            end
            S_RPY: begin
                w.nsel    = vfce_pkg::FACE_PY;
                w.cap_en  = 1'b1;
                w.cap_bit = vfce_pkg::FACE_NY;
            end
            S_RNZ: begin
                w.nsel    = vfce_pkg::FACE_NZ;
                w.cap_en  = 1'b1;
                w.cap_bit = vfce_pkg::FACE_PY;
            end
            S_RPZ: begin
                w.nsel    = vfce_pkg::FACE_PZ;
                w.cap_en  = 1'b1;
                w.cap_bit = vfce_pkg::FACE_NZ;
            end
            S_CPZ: begin
                w.cap_en  = 1'b1;
                w.cap_bit = vfce_pkg::FACE_PZ;
            end
            S_SEEK: begin
                w.seek   = 1'b1;
                w.jc     = vfce_pkg::JC_EMPTY;
                w.target = S_IDLE;
            end
            S_EMIT: begin
                w.emit   = 1'b1;
                w.jc     = vfce_pkg::JC_EMIT;
                w.target = S_SEEK;
            end
            default: begin
                w.jc     = vfce_pkg::JC_JUMP;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    assign ctl    = rom(r_pc);
    assign pc_inc = r_pc + 1'b1;

    always_comb begin
        unique case (ctl.jc)
            vfce_pkg::JC_NEXT:   n_pc = pc_inc;
            vfce_pkg::JC_JUMP:   n_pc = ctl.target;
            vfce_pkg::JC_ACCEPT: n_pc = i_stat.go ? pc_inc : r_pc;
            vfce_pkg::JC_ZERO:   n_pc = i_stat.data_zero ? ctl.target : pc_inc;
            vfce_pkg::JC_EMPTY:  n_pc = i_stat.mask_empty ? ctl.target : pc_inc;
            vfce_pkg::JC_EMIT:   n_pc = (i_stat.fire && i_stat.vert_last) ? ctl.target : r_pc;
            default:             n_pc = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl = ctl;

endmodule

`default_nettype wire

FILE: hw/rtl/vfce_dp.sv
// Datapath of the emitter: item latch, chunk registers, neighbor addressing,
// visibility mask, vertex counters and the output register.
// Depends on vfce_pkg; drives the voxel store RAM.
`default_nettype none

module vfce_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vfce_pkg::t_ctl                i_ctl,
    output vfce_pkg::t_stat               o_stat,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [vfce_pkg::VW-1:0]       i_vx,
    input  logic [vfce_pkg::VW-1:0]       i_vy,
    input  logic [vfce_pkg::VW-1:0]       i_vz,
    input  logic [vfce_pkg::BW-1:0]       i_block_id,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [vfce_pkg::CFGW-1:0]     i_cfg_data,
    output logic                          o_ram_we,
    output logic [vfce_pkg::AW-1:0]       o_ram_waddr,
    output logic [vfce_pkg::BW-1:0]       o_ram_wdata,
    output logic [vfce_pkg::AW-1:0]       o_ram_raddr,
    input  logic [vfce_pkg::BW-1:0]       i_ram_rdata,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [vfce_pkg::WW-1:0]       o_world_x,
    output logic [vfce_pkg::WW-1:0]       o_world_y,
    output logic [vfce_pkg::WW-1:0]       o_world_z,
    output logic [2:0]                    o_corner,
    output logic [2:0]                    o_tex_slot,
    output logic [2:0]                    o_face,
    output logic                          o_last
);

    logic [vfce_pkg::CFGW-1:0] r_chunk_x, r_chunk_y, r_chunk_z;
    logic [vfce_pkg::VW-1:0]   r_x, r_y, r_z;
    logic [vfce_pkg::VW-1:0]   nb_x, nb_y, nb_z;
    logic                      r_oob, n_oob;
    logic [5:0]                r_mask;
    logic [2:0]                r_face, r_vert;
    logic [2:0]                first_face;
    logic                      accepted, in_range, visible, fire, vert_last, others_empty;
    logic [5:0]                face_bit;

    logic                      r_ovalid;
    logic [vfce_pkg::WW-1:0]   r_owx, r_owy, r_owz;
    logic [2:0]                r_ocorner, r_otex, r_oface;
    logic                      r_olast;

    assign o_ready  = i_ctl.ready;
    assign accepted = i_valid && i_ctl.ready;
    assign in_range = ({1'b0, i_vx} < (vfce_pkg::VW + 1)'(vfce_pkg::EDGE))
                   && ({1'b0, i_vy} < (vfce_pkg::VW + 1)'(vfce_pkg::EDGE))
                   && ({1'b0, i_vz} < (vfce_pkg::VW + 1)'(vfce_pkg::EDGE));

    // Store writes happen right at the request handshake.
    assign o_ram_we    = accepted && (i_op == vfce_pkg::OP_WRITE) && in_range;
    assign o_ram_waddr = vfce_pkg::addr_of(i_vx, i_vy, i_vz);
    assign o_ram_wdata = i_block_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_x <= '0;
            r_chunk_y <= '0;
            r_chunk_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vfce_pkg::REG_CHUNK_X: r_chunk_x <= i_cfg_data;
                vfce_pkg::REG_CHUNK_Y: r_chunk_y <= i_cfg_data;
                vfce_pkg::REG_CHUNK_Z: r_chunk_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accepted) begin
            r_x <= i_vx;
            r_y <= i_vy;
            r_z <= i_vz;
        end
    end

    // Neighbor address and whether it falls outside the chunk. A wrapped
    // address is still read, but its data is ignored.
    always_comb begin
        nb_x  = r_x;
        nb_y  = r_y;
        nb_z  = r_z;
        n_oob = 1'b0;
        unique case (i_ctl.nsel)
            vfce_pkg::FACE_NX: begin
                nb_x  = r_x - 1'b1;
                n_oob = (r_x == '0);
            end
            vfce_pkg::FACE_PX: begin
                nb_x  = r_x + 1'b1;
                n_oob = (r_x == vfce_pkg::VW'(vfce_pkg::EDGE - 1));
            end
            vfce_pkg::FACE_NY: begin
                nb_y  = r_y - 1'b1;
                n_oob = (r_y == '0);
            end
            vfce_pkg::FACE_PY: begin
                nb_y  = r_y + 1'b1;
                n_oob = (r_y == vfce_pkg::VW'(vfce_pkg::EDGE - 1));
            end
            vfce_pkg::FACE_NZ: begin
                nb_z  = r_z - 1'b1;
                n_oob = (r_z == '0);
            end
            vfce_pkg::FACE_PZ: begin
                nb_z  = r_z + 1'b1;
                n_oob = (r_z == vfce_pkg::VW'(vfce_pkg::EDGE - 1));
            end
            default: ;
        endcase
    end

    assign o_ram_raddr = vfce_pkg::addr_of(nb_x, nb_y, nb_z);
    assign visible     = r_oob || (i_ram_rdata == '0);

    always_comb begin
        first_face = vfce_pkg::FACE_NX;
        for (int i = 5; i >= 0; i--) begin
            if (r_mask[i]) begin
                first_face = 3'(i);
            end
        end
    end

    assign face_bit     = 6'(6'd1 << r_face);
    assign others_empty = ((r_mask & ~face_bit) == '0);
    assign vert_last    = (r_vert == vfce_pkg::VERT_LAST);
    assign fire         = i_ctl.emit && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        r_oob <= n_oob;
        if (i_ctl.seek) begin
            r_face <= first_face;
            r_vert <= '0;
        end else if (fire) begin
            r_vert <= r_vert + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_ctl.cap_en) begin
            r_mask[i_ctl.cap_bit] <= visible;
        end else if (fire && vert_last) begin
            r_mask[r_face] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (fire) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_owx     <= vfce_pkg::world_pos(r_chunk_x, r_x);
            r_owy     <= vfce_pkg::world_pos(r_chunk_y, r_y);
            r_owz     <= vfce_pkg::world_pos(r_chunk_z, r_z);
            r_ocorner <= vfce_pkg::corner_lut(r_face, r_vert);
            r_otex    <= vfce_pkg::tex_lut(r_face, r_vert);
            r_oface   <= r_face;
            r_olast   <= vert_last && others_empty;
        end
    end

    assign o_stat.go         = accepted && (i_op == vfce_pkg::OP_MESH) && in_range;
    assign o_stat.data_zero  = (i_ram_rdata == '0);
    assign o_stat.mask_empty = (r_mask == '0);
    assign o_stat.fire       = fire;
    assign o_stat.vert_last  = vert_last;

    assign o_valid    = r_ovalid;
    assign o_world_x  = r_owx;
    assign o_world_y  = r_owy;
    assign o_world_z  = r_owz;
    assign o_corner   = r_ocorner;
    assign o_tex_slot = r_otex;
    assign o_face     = r_oface;
    assign o_last     = r_olast;

endmodule

`default_nettype wire

FILE: hw/rtl/vfce_chk.sv
// Port-level checker for the voxel face-cull emitter, bound to the top level.
// Depends on vfce_pkg for operation and face codes.
`default_nettype none

module vfce_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic                             i_op,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic signed [vfce_pkg::WW-1:0]   o_world_x,
    input logic signed [vfce_pkg::WW-1:0]   o_world_y,
    input logic signed [vfce_pkg::WW-1:0]   o_world_z,
    input logic [2:0]                       o_corner,
    input logic [2:0]                       o_tex_slot,
    input logic [2:0]                       o_face,
    input logic                             o_last
);

    // A stalled vertex keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid
            && $stable({o_world_x, o_world_y, o_world_z, o_corner, o_tex_slot, o_face, o_last}))
        else $error("stalled vertex changed");

    a_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_face <= vfce_pkg::FACE_PZ)
        else $error("face code out of range");

    // While more vertices of a mesh request are pending, no new request is taken.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("request taken in the middle of a vertex run");

    a_mesh_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_op == vfce_pkg::OP_MESH |=> !o_ready)
        else $error("ready right after a mesh request");

    // All vertices of one request share one world position.
    a_world: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> $stable(o_world_x) && $stable(o_world_y)
            && $stable(o_world_z))
        else $error("world position changed within a request");

endmodule

bind voxel_face_cull_emitter vfce_chk u_vfce_chk (.*);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for voxel_face_cull_emitter: random and corner-case voxel
// writes and mesh requests, checked vertex by vertex against a local model.
// Depends on vfce_pkg and the voxel_face_cull_emitter RTL only.
`timescale 1ns / 1ps

module testbench;

    localparam int SETTLE_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int HOLD_CYCLES      = 300;
    localparam int RANDOM_PER_PHASE = 78;

    // Neighbor offsets, indexed by face code.
    localparam int STEP_X [6] = '{-1, 1, 0, 0, 0, 0};
    localparam int STEP_Y [6] = '{0, 0, -1, 1, 0, 0};
    localparam int STEP_Z [6] = '{0, 0, 0, 0, -1, 1};

    localparam logic [2:0] CORNER_OF [6][6] = '{
        '{3'd0, 3'd6, 3'd2, 3'd0, 3'd4, 3'd6},
        '{3'd1, 3'd3, 3'd7, 3'd1, 3'd7, 3'd5},
        '{3'd0, 3'd5, 3'd4, 3'd0, 3'd1, 3'd5},
        '{3'd2, 3'd6, 3'd7, 3'd2, 3'd7, 3'd3},
        '{3'd0, 3'd2, 3'd3, 3'd0, 3'd3, 3'd1},
        '{3'd4, 3'd7, 3'd6, 3'd4, 3'd5, 3'd7}
    };

    localparam logic [2:0] TEX_OF [6][6] = '{
        '{3'd3, 3'd4, 3'd2, 3'd3, 3'd5, 3'd4},
        '{3'd5, 3'd4, 3'd2, 3'd5, 3'd2, 3'd3},
        '{3'd6, 3'd5, 3'd7, 3'd6, 3'd4, 3'd5},
        '{3'd3, 3'd2, 3'd0, 3'd3, 3'd0, 3'd1},
        '{3'd5, 3'd4, 3'd2, 3'd5, 3'd2, 3'd3},
        '{3'd3, 3'd4, 3'd2, 3'd3, 3'd5, 3'd4}
    };

    typedef struct {
        logic                    op;
        logic [vfce_pkg::VW-1:0] x;
        logic [vfce_pkg::VW-1:0] y;
        logic [vfce_pkg::VW-1:0] z;
        logic [vfce_pkg::BW-1:0] id;
    } t_voxel_req;

    typedef struct packed {
        logic [vfce_pkg::WW-1:0] wx;
        logic [vfce_pkg::WW-1:0] wy;
        logic [vfce_pkg::WW-1:0] wz;
        logic [2:0]              corner;
        logic [2:0]              tex;
        logic [2:0]              face;
        logic                    last;
    } t_vertex;

    logic                           i_clk;
    logic                           i_rst_n    = 1'b0;
    logic                           i_valid    = 1'b0;
    logic                           o_ready;
    logic                           i_op       = vfce_pkg::OP_WRITE;
    logic [vfce_pkg::VW-1:0]        i_vx       = '0;
    logic [vfce_pkg::VW-1:0]        i_vy       = '0;
    logic [vfce_pkg::VW-1:0]        i_vz       = '0;
    logic [vfce_pkg::BW-1:0]        i_block_id = '0;
    logic                           o_valid;
    logic                           i_ready    = 1'b0;
    logic signed [vfce_pkg::WW-1:0] o_world_x;
    logic signed [vfce_pkg::WW-1:0] o_world_y;
    logic signed [vfce_pkg::WW-1:0] o_world_z;
    logic [2:0]                     o_corner;
    logic [2:0]                     o_tex_slot;
    logic [2:0]                     o_face;
    logic                           o_last;
    logic                           i_cfg_we   = 1'b0;
    logic [1:0]                     i_cfg_idx  = vfce_pkg::REG_CHUNK_X;
    logic [vfce_pkg::CFGW-1:0]      i_cfg_data = '0;

    t_voxel_req                pending_reqs[$];
    t_vertex                   expected_verts[$];
    logic [vfce_pkg::BW-1:0]   voxel_shadow [vfce_pkg::DEPTH];
    bit                        written_map [vfce_pkg::DEPTH];
    logic [vfce_pkg::CFGW-1:0] chunk_reg [3];

    int  send_idle_pct    = 0;
    int  stall_pct        = 0;
    bit  hold_active      = 1'b0;
    int  hold_count       = 0;
    bit  in_taken         = 1'b0;
    bit  out_taken        = 1'b0;
    int  items_planned    = 0;
    int  reqs_taken       = 0;
    int  mesh_count       = 0;
    int  lit_meshes       = 0;
    int  vertices_checked = 0;
    int  cfg_writes       = 0;
    int  mismatches       = 0;
    int  quiet_cycles     = 0;

    voxel_face_cull_emitter u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_op       (i_op),
        .i_vx       (i_vx),
        .i_vy       (i_vy),
        .i_vz       (i_vz),
        .i_block_id (i_block_id),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_world_x  (o_world_x),
        .o_world_y  (o_world_y),
        .o_world_z  (o_world_z),
        .o_corner   (o_corner),
        .o_tex_slot (o_tex_slot),
        .o_face     (o_face),
        .o_last     (o_last),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int voxel_index(input int x, input int y, input int z);
        return (x * vfce_pkg::EDGE + y) * vfce_pkg::EDGE + z;
    endfunction

    function automatic bit in_chunk(input int x, input int y, input int z);
        return x >= 0 && y >= 0 && z >= 0
            && x < vfce_pkg::EDGE && y < vfce_pkg::EDGE && z < vfce_pkg::EDGE;
    endfunction

    function automatic logic [vfce_pkg::WW-1:0] world_coord(
            input logic [vfce_pkg::CFGW-1:0] chunk, input logic [vfce_pkg::VW-1:0] v);
        int sum;
        sum = $signed(chunk) * vfce_pkg::EDGE + int'(v);
        return sum[vfce_pkg::WW-1:0];
    endfunction

    // Applies one accepted request to the local voxel copy and queues the
    // vertices it should produce, faces in code order.
    task automatic predict_req(input t_voxel_req r);
        logic [5:0] open_faces;
        int         final_face;
        int         nx, ny, nz;
        t_vertex    vtx;
        if (r.op == vfce_pkg::OP_WRITE) begin
            voxel_shadow[voxel_index(r.x, r.y, r.z)] = r.id;
            return;
        end
        mesh_count++;
        if (voxel_shadow[voxel_index(r.x, r.y, r.z)] == '0)
            return;
        open_faces = '0;
        final_face = -1;
        for (int f = vfce_pkg::FACE_NX; f <= vfce_pkg::FACE_PZ; f++) begin
            nx = int'(r.x) + STEP_X[f];
            ny = int'(r.y) + STEP_Y[f];
            nz = int'(r.z) + STEP_Z[f];
            if (!in_chunk(nx, ny, nz))
                open_faces[f] = 1'b1;
            else
                open_faces[f] = (voxel_shadow[voxel_index(nx, ny, nz)] == '0);
            if (open_faces[f])
                final_face = f;
        end
        if (final_face >= 0)
            lit_meshes++;
        for (int f = vfce_pkg::FACE_NX; f <= vfce_pkg::FACE_PZ; f++) begin
            if (open_faces[f]) begin
                for (int v = 0; v <= vfce_pkg::VERT_LAST; v++) begin
                    vtx.wx     = world_coord(chunk_reg[vfce_pkg::REG_CHUNK_X], r.x);
                    vtx.wy     = world_coord(chunk_reg[vfce_pkg::REG_CHUNK_Y], r.y);
                    vtx.wz     = world_coord(chunk_reg[vfce_pkg::REG_CHUNK_Z], r.z);
                    vtx.corner = CORNER_OF[f][v];
                    vtx.tex    = TEX_OF[f][v];
                    vtx.face   = 3'(f);
                    vtx.last   = (f == final_face) && (v == vfce_pkg::VERT_LAST);
                    expected_verts = {expected_verts, vtx};
                end
            end
        end
    endtask

    task automatic log_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [vfce_pkg::WW-1:0] got,
                               input logic [vfce_pkg::WW-1:0] want);
        if (got !== want)
            log_mismatch($sformatf("vertex %0d %s got %0h expected %0h",
                                   vertices_checked, name, got, want));
    endtask

    task automatic compare_vertex(input t_vertex got, input t_vertex want);
        check_field("world_x", got.wx, want.wx);
        check_field("world_y", got.wy, want.wy);
        check_field("world_z", got.wz, want.wz);
        check_field("corner", vfce_pkg::WW'(got.corner), vfce_pkg::WW'(want.corner));
        check_field("tex_slot", vfce_pkg::WW'(got.tex), vfce_pkg::WW'(want.tex));
        check_field("face", vfce_pkg::WW'(got.face), vfce_pkg::WW'(want.face));
        check_field("last", vfce_pkg::WW'(got.last), vfce_pkg::WW'(want.last));
    endtask

    // Sample both handshakes at the rising edge; the watchdog lives here too.
    always @(posedge i_clk) begin
        t_vertex    seen;
        t_voxel_req req;
        in_taken  = i_rst_n && i_valid && o_ready;
        out_taken = i_rst_n && o_valid && i_ready;
        if (in_taken) begin
            req.op = i_op;
            req.x  = i_vx;
            req.y  = i_vy;
            req.z  = i_vz;
            req.id = i_block_id;
            predict_req(req);
            reqs_taken++;
        end
        if (out_taken) begin
            seen.wx     = o_world_x;
            seen.wy     = o_world_y;
            seen.wz     = o_world_z;
            seen.corner = o_corner;
            seen.tex    = o_tex_slot;
            seen.face   = o_face;
            seen.last   = o_last;
            if (expected_verts.size() == 0)
                log_mismatch($sformatf("vertex %0d arrived with none expected",
                                       vertices_checked));
            else
                compare_vertex(seen, expected_verts.pop_front());
            vertices_checked++;
        end
        if (in_taken || out_taken || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no request or vertex moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Request driver: presents the next pending request once the previous one is gone.
    always @(negedge i_clk) begin
        t_voxel_req nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_reqs.pop_front();
                i_valid    <= 1'b1;
                i_op       <= nxt.op;
                i_vx       <= nxt.x;
                i_vy       <= nxt.y;
                i_vz       <= nxt.z;
                i_block_id <= nxt.id;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Vertex sink: random stalls, plus one long hold so the block backs up.
    always @(negedge i_clk) begin
        if (hold_active && hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
            i_ready    <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [vfce_pkg::BW-1:0] random_block();
        if ($urandom_range(0, 99) < 45)
            return '0;
        return vfce_pkg::BW'($urandom_range(1, 255));
    endfunction

    function automatic int pick_axis(input int base);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return base + $urandom_range(0, 3);
        if (roll < 90)
            return $urandom_range(0, vfce_pkg::EDGE - 1);
        return $urandom_range(0, 1) ? vfce_pkg::EDGE - 1 : 0;
    endfunction

    task automatic queue_req(input logic op, input int x, input int y, input int z,
                             input logic [vfce_pkg::BW-1:0] id);
        t_voxel_req r;
        r.op = op;
        r.x  = vfce_pkg::VW'(x);
        r.y  = vfce_pkg::VW'(y);
        r.z  = vfce_pkg::VW'(z);
        r.id = id;
        pending_reqs = {pending_reqs, r};
        items_planned++;
        if (op == vfce_pkg::OP_WRITE)
            written_map[voxel_index(x, y, z)] = 1'b1;
    endtask

    // A mesh request is only issued once the voxel and every in-chunk
    // neighbor have been written; missing ones get a random value first.
    task automatic plan_mesh(input int x, input int y, input int z,
                             input logic [vfce_pkg::BW-1:0] id);
        int nx, ny, nz;
        if (!written_map[voxel_index(x, y, z)])
            queue_req(vfce_pkg::OP_WRITE, x, y, z, random_block());
        for (int f = vfce_pkg::FACE_NX; f <= vfce_pkg::FACE_PZ; f++) begin
            nx = x + STEP_X[f];
            ny = y + STEP_Y[f];
            nz = z + STEP_Z[f];
            if (in_chunk(nx, ny, nz) && !written_map[voxel_index(nx, ny, nz)])
                queue_req(vfce_pkg::OP_WRITE, nx, ny, nz, random_block());
        end
        queue_req(vfce_pkg::OP_MESH, x, y, z, id);
    endtask

    task automatic queue_corner_cases();
        int hi;
        hi = vfce_pkg::EDGE - 1;
        // Corner voxel with all neighbors air shows all six faces.
        queue_req(vfce_pkg::OP_WRITE, 1, 0, 0, 8'd0);
        queue_req(vfce_pkg::OP_WRITE, 0, 1, 0, 8'd0);
        queue_req(vfce_pkg::OP_WRITE, 0, 0, 1, 8'd0);
        queue_req(vfce_pkg::OP_WRITE, 0, 0, 0, 8'hff);
        plan_mesh(0, 0, 0, 8'hff);
        // Far corner with solid inner neighbors shows only the outer faces.
        queue_req(vfce_pkg::OP_WRITE, hi - 1, hi, hi, 8'd1);
        queue_req(vfce_pkg::OP_WRITE, hi, hi - 1, hi, 8'd2);
        queue_req(vfce_pkg::OP_WRITE, hi, hi, hi - 1, 8'd3);
        queue_req(vfce_pkg::OP_WRITE, hi, hi, hi, 8'h80);
        plan_mesh(hi, hi, hi, 8'h00);
        // Meshing air gives nothing.
        plan_mesh(1, 0, 0, 8'h5a);
        // A voxel buried on all six sides gives nothing either.
        queue_req(vfce_pkg::OP_WRITE, 7, 8, 8, 8'h11);
        queue_req(vfce_pkg::OP_WRITE, 9, 8, 8, 8'h22);
        queue_req(vfce_pkg::OP_WRITE, 8, 7, 8, 8'h33);
        queue_req(vfce_pkg::OP_WRITE, 8, 9, 8, 8'h44);
        queue_req(vfce_pkg::OP_WRITE, 8, 8, 7, 8'h55);
        queue_req(vfce_pkg::OP_WRITE, 8, 8, 9, 8'h66);
        queue_req(vfce_pkg::OP_WRITE, 8, 8, 8, 8'h07);
        plan_mesh(8, 8, 8, 8'haa);
    endtask

    // Random traffic clustered in a small window so neighbors really interact.
    task automatic fill_random(input int count);
        int start;
        int bx, by, bz;
        int x, y, z;
        start = items_planned;
        bx = $urandom_range(0, vfce_pkg::EDGE - 4);
        by = $urandom_range(0, vfce_pkg::EDGE - 4);
        bz = $urandom_range(0, vfce_pkg::EDGE - 4);
        while (items_planned - start < count) begin
            x = pick_axis(bx);
            y = pick_axis(by);
            z = pick_axis(bz);
            if ($urandom_range(0, 99) < 60)
                plan_mesh(x, y, z, vfce_pkg::BW'($urandom_range(0, 255)));
            else
                queue_req(vfce_pkg::OP_WRITE, x, y, z, random_block());
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [vfce_pkg::CFGW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        chunk_reg[idx] = val;
        cfg_writes++;
    endtask

    // Write items and air meshes give no vertex, so the block may still be
    // busy after the last vertex; give it a full item time before moving on.
    task automatic drain_and_settle();
        do @(negedge i_clk);
        while (reqs_taken != items_planned || expected_verts.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [vfce_pkg::CFGW-1:0] cx,
                             input logic [vfce_pkg::CFGW-1:0] cy,
                             input logic [vfce_pkg::CFGW-1:0] cz, input int send_idle,
                             input int stall, input bit squeeze, input bit corner_cases);
        write_reg(vfce_pkg::REG_CHUNK_X, cx);
        write_reg(vfce_pkg::REG_CHUNK_Y, cy);
        write_reg(vfce_pkg::REG_CHUNK_Z, cz);
        @(negedge i_clk);
        i_cfg_we      <= 1'b0;
        send_idle_pct <= send_idle;
        stall_pct     <= stall;
        hold_active   <= squeeze;
        @(posedge i_clk);
        if (corner_cases)
            queue_corner_cases();
        fill_random(RANDOM_PER_PHASE);
        drain_and_settle();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_phase(16'h0000, 16'h0000, 16'h0000, 0, 0, 1'b0, 1'b1);
        run_phase(16'h7fff, 16'h7fff, 16'h7fff, 69, 0, 1'b0, 1'b0);
        run_phase(16'h8000, 16'h8000, 16'h8000, 0, 69, 1'b0, 1'b0);
        run_phase(vfce_pkg::CFGW'($urandom_range(0, 65535)),
                  vfce_pkg::CFGW'($urandom_range(0, 65535)),
                  vfce_pkg::CFGW'($urandom_range(0, 65535)), 32, 32, 1'b0, 1'b0);
        run_phase(16'h8000, 16'h7fff, vfce_pkg::CFGW'($urandom_range(0, 65535)),
                  0, 0, 1'b1, 1'b0);
        $display("Run: %0d requests, %0d meshes (%0d with visible faces), %0d vertices",
                 reqs_taken, mesh_count, lit_meshes, vertices_checked);
        $display("Chunk offsets at both extremes over %0d register writes, %s %0d-cycle hold",
                 cfg_writes, "gaps, stalls and a", HOLD_CYCLES);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
